// File: hw/rtl/argsrt_pkg.sv
// Package for the argsort engine: field widths, the cell payload type and
// the cell operation codes. No dependencies.
package argsrt_pkg;

  localparam int unsigned ValW = 32;  // element value width
  localparam int unsigned IdxW = 6;   // arrival index width

  // Payload held by one cell of the sorting row.
  typedef struct packed {
    logic [ValW-1:0] value;
    logic [IdxW-1:0] index;
  } elem_t;

  // Operation applied to all cells of the row together.
  typedef enum logic [1:0] {
    CELL_HOLD     = 2'd0,
    CELL_INSERT   = 2'd1,
    CELL_SHIFT_DN = 2'd2,  // take the higher neighbor's content
    CELL_SHIFT_UP = 2'd3   // take the lower neighbor's content
  } cell_op_e;

endpackage

// File: hw/rtl/argsort_engine.sv
// Top level of the argsort engine: APB register, stream ports, the row of
// sorting cells and the output register. Depends on argsrt_pkg, argsrt_cell.

// The engine takes signed 32-bit values one beat at a time and sorts them
// as they arrive in a row of MAX_ELEMENTS cells: every cell compares the
// broadcast newcomer with what it holds and either keeps its element, takes
// the newcomer, or takes its lower neighbor's element, so one input beat is
// absorbed per cycle. The beat with tlast set closes the set; from the next
// cycle the row drains one result per cycle, unless the output stalls, into
// an output register, which lets the last result wait while new input is
// already being taken. In descending order the run leaves from the low end
// of the row; in ascending order it leaves from the high end, once the run
// has travelled there along the row. Input is not accepted while the row
// drains. Elements beyond MAX_ELEMENTS are dropped and every result of that
// set carries the overflow flag in tuser. Equal values come out in rising
// arrival order when sorting descending and in falling arrival order when
// sorting ascending. The sort_descending register (byte address 0, bit 0,
// reset 1) is sampled at the closing beat. No clearing pass is needed after
// reset.
module argsort_engine #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tlast,   // final_element
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] sorted_value, [37:32] source_index, zero pad
  output logic        m_axis_tlast,   // end_of_run
  output logic        m_axis_tuser    // overflowed
);

  localparam int unsigned CntW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Configuration register.
  logic desc_q, desc_d;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign desc_d = cfg_wr ? pwdata[0] : desc_q;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, desc_q} : 32'd0;

  // Set bookkeeping.
  logic [CntW-1:0] count_q, count_d, count_inc;
  logic            ovf_q, ovf_d;
  logic            full;
  logic            in_beat;
  logic [CntW-1:0] rem_q, rem_d;
  logic            run_ovf_q, run_ovf_d;
  logic            dir_q, dir_d;      // 1: drain descending from cell 0

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CntW'(MAX_ELEMENTS));
  assign count_inc     = count_q + CntW'(1);

  // Cell row.
  argsrt_pkg::elem_t   cell_elem  [MAX_ELEMENTS];
  logic                cell_valid [MAX_ELEMENTS];
  logic                cell_ahead [MAX_ELEMENTS];
  argsrt_pkg::cell_op_e cell_op;
  argsrt_pkg::elem_t   new_elem;

  assign new_elem.value = s_axis_tdata;
  assign new_elem.index = argsrt_pkg::IdxW'(count_q);

  // Output register and drain control.
  argsrt_pkg::elem_t end_elem;
  logic              end_valid;
  logic              out_room;
  logic              pop;
  logic              shift;
  logic              out_valid_q, out_valid_d;
  argsrt_pkg::elem_t out_elem_q, out_elem_d;
  logic              out_last_q, out_last_d;
  logic              out_ovf_q, out_ovf_d;
  logic              run_last;

  assign end_elem  = dir_q ? cell_elem[0] : cell_elem[MAX_ELEMENTS-1];
  assign end_valid = dir_q ? cell_valid[0] : cell_valid[MAX_ELEMENTS-1];
  assign out_room  = !out_valid_q || m_axis_tready;
  assign pop       = (state_q == ST_DRAIN) && end_valid && out_room;
  // In ascending order the run first travels to the high end; empty cells
  // arriving there are skipped without producing a beat.
  assign shift     = (state_q == ST_DRAIN) && (!end_valid || pop);
  assign run_last  = (rem_q == CntW'(1));

  always_comb begin
    if (shift) begin
      cell_op = dir_q ? argsrt_pkg::CELL_SHIFT_DN : argsrt_pkg::CELL_SHIFT_UP;
    end else if (in_beat && !full) begin
      cell_op = argsrt_pkg::CELL_INSERT;
    end else begin
      cell_op = argsrt_pkg::CELL_HOLD;
    end
  end

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    argsrt_pkg::elem_t prev_elem, next_elem;
    logic              prev_valid, next_valid, prev_ahead;

    if (i == 0) begin : g_first
      assign prev_elem  = '0;
      assign prev_valid = 1'b0;
      assign prev_ahead = 1'b1;
    end else begin : g_mid_lo
      assign prev_elem  = cell_elem[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_ahead = cell_ahead[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_last
      assign next_elem  = '0;
      assign next_valid = 1'b0;
    end else begin : g_mid_hi
      assign next_elem  = cell_elem[i+1];
      assign next_valid = cell_valid[i+1];
    end

    argsrt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (cell_op),
      .new_i        (new_elem),
      .prev_i       (prev_elem),
      .prev_valid_i (prev_valid),
      .prev_ahead_i (prev_ahead),
      .next_i       (next_elem),
      .next_valid_i (next_valid),
      .elem_o       (cell_elem[i]),
      .valid_o      (cell_valid[i]),
      .ahead_o      (cell_ahead[i])
    );
  end

  // Control: loading, closing a set and draining it.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    rem_d     = rem_q;
    run_ovf_d = run_ovf_q;
    dir_d     = dir_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_beat) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_inc;
          end
          if (s_axis_tlast) begin
            state_d   = ST_DRAIN;
            count_d   = '0;
            ovf_d     = 1'b0;
            rem_d     = full ? CntW'(MAX_ELEMENTS) : count_inc;
            run_ovf_d = ovf_q || full;
            dir_d     = desc_q;
          end
        end
      end
      ST_DRAIN: begin
        if (pop) begin
          rem_d = rem_q - CntW'(1);
          if (run_last) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_elem_d  = out_elem_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    if (pop) begin
      out_valid_d = 1'b1;
      out_elem_d  = end_elem;
      out_last_d  = run_last;
      out_ovf_d   = run_ovf_q;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      desc_q      <= 1'b1;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      rem_q       <= '0;
      run_ovf_q   <= 1'b0;
      dir_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      desc_q      <= desc_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      rem_q       <= rem_d;
      run_ovf_q   <= run_ovf_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_elem_q <= out_elem_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_elem_q.index, out_elem_q.value};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule

// File: hw/rtl/argsrt_cell.sv
// One cell of the systolic insertion row of the argsort engine.
// Depends on argsrt_pkg for the payload type and the operation codes.
module argsrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  argsrt_pkg::cell_op_e op_i,
  input  argsrt_pkg::elem_t   new_i,
  input  argsrt_pkg::elem_t   prev_i,
  input  logic                prev_valid_i,
  input  logic                prev_ahead_i,
  input  argsrt_pkg::elem_t   next_i,
  input  logic                next_valid_i,
  output argsrt_pkg::elem_t   elem_o,
  output logic                valid_o,
  output logic                ahead_o
);

  argsrt_pkg::elem_t elem_q, elem_d;
  logic              valid_q, valid_d;
  logic              own_ahead;

  // A held element stays ahead of a newcomer on equal values, since the
  // newcomer always carries the highest arrival index so far.
  assign own_ahead = valid_q && ($signed(elem_q.value) >= $signed(new_i.value));

  always_comb begin
    elem_d  = elem_q;
    valid_d = valid_q;
    unique case (op_i)
      argsrt_pkg::CELL_HOLD: begin
      end
      argsrt_pkg::CELL_INSERT: begin
        if (!own_ahead) begin
          if (prev_ahead_i) begin
            elem_d  = new_i;
            valid_d = 1'b1;
          end else begin
            elem_d  = prev_i;
            valid_d = prev_valid_i;
          end
        end
      end
      argsrt_pkg::CELL_SHIFT_DN: begin
        elem_d  = next_i;
        valid_d = next_valid_i;
      end
      argsrt_pkg::CELL_SHIFT_UP: begin
        elem_d  = prev_i;
        valid_d = prev_valid_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  assign elem_o  = elem_q;
  assign valid_o = valid_q;
  assign ahead_o = own_ahead;

endmodule

// File: hw/rtl/argsrt_checker.sv
// Port-level checker for the argsort engine and its bind to the top level.
// Depends only on the ports of argsort_engine.
module argsrt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // A closing beat starts the drain, which deasserts input ready once the drain state is registered.
  a_close_stops_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still ready after the closing beat");

  // Input reopens exactly when the final result of the run is presented.
  a_reopen_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> (m_axis_tvalid && m_axis_tlast))
    else $error("input reopened without the final result on the output");

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
       && $stable(m_axis_tuser)))
    else $error("stalled output beat changed");

endmodule

bind argsort_engine argsrt_checker u_argsrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// File: test/tb_argsort_engine.sv
// Self-checking testbench for argsort_engine: stream and APB stimulus, a
// scoreboard class that predicts every sorted run. Depends on argsrt_pkg.
module tb_argsort_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ValW = argsrt_pkg::ValW;
  localparam int unsigned IdxW = argsrt_pkg::IdxW;
  localparam int unsigned Capacity = 64;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned RandomBeats = 450;
  localparam int unsigned NumPhases = 4;
  // Register map: the sort order bit is the only register; the next word
  // is unmapped and writes there must be ignored.
  localparam logic [2:0] RegSortOrderAddr = 3'd0;
  localparam logic [2:0] RegUnmappedAddr = 3'd4;
  localparam logic signed [ValW-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [ValW-1:0] ValMax = 32'sh7fff_ffff;

  // Predicts the sorted runs and checks every output beat against them.
  class sort_scoreboard;
    typedef struct {
      logic signed [ValW-1:0] value;
      logic [IdxW-1:0]        index;
    } element_t;
    typedef struct {
      logic [ValW-1:0] value;
      logic [IdxW-1:0] index;
      logic            run_end;
      logic            dropped;
    } sorted_beat_t;

    element_t     open_set[$];
    sorted_beat_t expected_runs[$];
    bit           set_dropped;
    bit           descending = 1'b1;
    int           mismatches;
    int           beats_checked;
    int           runs_closed;
    int           overflow_runs;

    function int pending();
      return expected_runs.size();
    endfunction

    function void report(string msg);
      if (mismatches < 10) $display("%t mismatch: %s", $realtime, msg);
      mismatches++;
    endfunction

    // Stores one accepted element; on the closing beat the set is ranked
    // (largest first, equal values by rising arrival index) and queued.
    function void note_element(logic [ValW-1:0] value, logic closing);
      element_t     elem;
      element_t     ranked[$];
      sorted_beat_t beat;
      int           pos;
      int           n;
      if (open_set.size() < Capacity) begin
        elem.value = value;
        elem.index = IdxW'(open_set.size());
        open_set.insert(open_set.size(), elem);
      end else begin
        set_dropped = 1'b1;
      end
      if (!closing) return;
      foreach (open_set[i]) begin
        pos = ranked.size();
        while (pos > 0 && open_set[i].value > ranked[pos-1].value) pos--;
        ranked.insert(pos, open_set[i]);
      end
      n = ranked.size();
      for (int k = 0; k < n; k++) begin
        elem = descending ? ranked[k] : ranked[n-1-k];
        beat.value = elem.value;
        beat.index = elem.index;
        beat.run_end = (k == n - 1);
        beat.dropped = set_dropped;
        expected_runs.insert(expected_runs.size(), beat);
      end
      runs_closed++;
      if (set_dropped) overflow_runs++;
      open_set.delete();
      set_dropped = 1'b0;
    endfunction

    function void check_beat(logic [39:0] data, logic run_end, logic dropped);
      sorted_beat_t want;
      beats_checked++;
      if (expected_runs.size() == 0) begin
        report($sformatf("unexpected beat value=%0d index=%0d last=%b ovf=%b",
                         $signed(data[31:0]), data[37:32], run_end, dropped));
        return;
      end
      want = expected_runs.pop_front();
      if (data[31:0] !== want.value || data[37:32] !== want.index ||
          data[39:38] !== 2'b00 || run_end !== want.run_end ||
          dropped !== want.dropped) begin
        report($sformatf({"expected value=%0d index=%0d last=%b ovf=%b, ",
                          "got value=%0d index=%0d pad=%b last=%b ovf=%b"},
                         $signed(want.value), want.index, want.run_end, want.dropped,
                         $signed(data[31:0]), data[37:32], data[39:38], run_end,
                         dropped));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // [31:0] value
  logic        s_tlast = 1'b0;  // final_element
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // [31:0] sorted_value, [37:32] source_index, zero pad
  logic        m_tlast;         // end_of_run
  logic        m_tuser;         // overflowed

  // Idling controls set by the stimulus between sets, the sink's stall counter and progress counters.
  bit gaps_on;
  bit stalls_on;
  int stall_left;
  int quiet_cycles;
  int beats_sent;

  sort_scoreboard sb = new();

  argsort_engine #(
    .MAX_ELEMENTS(Capacity)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .m_axis_tuser  (m_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Output side: check each accepted beat, then decide whether the sink
  // stalls on the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast, m_tuser);
    if (stall_left > 0) begin
      stall_left--;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    m_tready <= rst_ni && (stall_left == 0);
  end

  // Watchdog: any accepted beat or register write counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("watchdog expired with %0d beats outstanding", sb.pending());
      $display("status: fail");
      $finish;
    end
  end

  // APB write: setup cycle, then access until pready.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == RegSortOrderAddr) sb.descending = data[0];
  endtask

  // Sets the sort order; the upper bits carry random junk that the block
  // has to ignore.
  task automatic set_order(input bit descending);
    reg_write(RegSortOrderAddr, {31'($urandom_range(0, 32'h7fff_ffff)), descending});
  endtask

  // Drives one input beat, optionally after a gap, and waits for acceptance.
  task automatic send_element(input logic [31:0] value, input logic closing);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    s_tlast <= closing;
    do @(posedge clk_i); while (!s_tready);
    sb.note_element(value, closing);
    beats_sent++;
  endtask

  // Values lean toward narrow ranges and extremes so ties and the sign
  // boundary show up often, with plenty of full-width random words.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 32'($signed($urandom_range(0, 6)) - 3);
      1: begin
        case ($urandom_range(0, 3))
          0: return ValMin;
          1: return ValMax;
          2: return 32'd0;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++) send_element(pick_value(), i == n - 1);
  endtask

  // Holds until every predicted beat has come back, then lets the row
  // settle before the register is touched.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int target;
    int n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets in the reset order (largest first): a single element,
    // both extremes with the values around zero, and a run of equal values.
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    send_element(ValMin, 1'b1);
    send_element(ValMax, 1'b0);
    send_element(ValMin, 1'b0);
    send_element(32'd0, 1'b0);
    send_element(32'hffff_ffff, 1'b0);
    send_element(32'd1, 1'b1);
    send_element(32'd7, 1'b0);
    send_element(-32'sd3, 1'b0);
    send_element(32'd7, 1'b0);
    send_element(32'd7, 1'b0);
    send_element(-32'sd3, 1'b1);
    drain();

    // Same ties and extremes with smallest first, so equal values must come
    // out in falling arrival order. A write to the unmapped word must not
    // disturb the order bit.
    set_order(1'b0);
    reg_write(RegUnmappedAddr, 32'hffff_ffff);
    send_element(32'd7, 1'b0);
    send_element(-32'sd3, 1'b0);
    send_element(32'd7, 1'b0);
    send_element(32'd7, 1'b0);
    send_element(-32'sd3, 1'b1);
    send_element(ValMax, 1'b0);
    send_element(ValMin, 1'b1);
    drain();

    // Random phases, alternating the sort order. The first three open with a set
    // at or beyond the capacity: exactly full, full with the closing beat
    // dropped, and several elements dropped; the last opens with a single
    // element and runs with no gaps and no stalls.
    for (int phase = 0; phase < NumPhases; phase++) begin
      set_order(phase % 2 == 0);
      target = beats_sent + RandomBeats / NumPhases;
      gaps_on = (phase != NumPhases - 1);
      stalls_on = gaps_on;
      case (phase)
        0: send_random_set(Capacity);
        1: send_random_set(Capacity + 1);
        2: send_random_set(Capacity + 6);
        default: send_random_set(1);
      endcase
      while (beats_sent < target) begin
        if (phase != NumPhases - 1) begin
          gaps_on = ($urandom_range(0, 3) != 0);
          stalls_on = ($urandom_range(0, 3) != 0);
        end
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
        send_random_set(n);
      end
      drain();
    end

    // The ascending drain of a full row is the longest stretch of latency.
    repeat (Capacity + 8) @(posedge clk_i);
    $display("sent %0d beats in %0d sets, %0d of them overflowing; %0d beats checked",
             beats_sent, sb.runs_closed, sb.overflow_runs, sb.beats_checked);
    $display("both sort orders, ties, value extremes and random idling covered");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d beats outstanding", sb.mismatches, sb.pending());
      $display("status: fail");
    end
    $finish;
  end

endmodule
